/* hw/rtl/pbfe_pkg.sv */
// package for the packet bit field extractor
// command codes, fixed field widths, controller/datapath structs, host swap rule
// no dependencies
`timescale 1ns / 1ps

package pbfe_pkg;

	localparam int PBFE_PACKET_BYTES = 2048;
	localparam int BUF_BITS          = 72;
	localparam int FIELD_BITS        = 64;
	localparam int SIZE_BITS         = 7;
	localparam int OFFSET_BITS       = 12;
	localparam int CMD_BITS          = 2;

	localparam logic [CMD_BITS-1:0] CMD_STORE   = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_READ    = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_REALIGN = 2'd2;
	localparam logic [CMD_BITS-1:0] CMD_END     = 2'd3;

	localparam logic [SIZE_BITS-1:0] MAX_FIELD = 7'd64;

	// commands from controller to datapath
	typedef struct packed {
		logic capture;
		logic store_byte;
		logic clear_packet;
		logic check;
		logic fill_read;
		logic fill_load;
		logic extract;
		logic load_out;
	} pbfe_ctl_t;

	// status from datapath to controller
	typedef struct packed {
		logic                skip;
		logic                need_fill;
	} pbfe_stat_t;

	// byte swap of a big-endian field as seen on a little-endian host
	function automatic logic [FIELD_BITS-1:0] host_swap(
		input logic [FIELD_BITS-1:0] v,
		input logic [SIZE_BITS-1:0]  n
	);
		logic [FIELD_BITS-1:0] r;
		r = v;
		if (n >= 7'd16 && n < 7'd32) begin
			r = {48'd0, v[7:0], v[15:8]};
		end else if (n == 7'd32) begin
			r = {32'd0, v[7:0], v[15:8], v[23:16], v[31:24]};
		end else if (n > 7'd32) begin
			for (int i = 0; i < 8; i++) begin
				r[8*i +: 8] = v[56-8*i +: 8];
			end
		end
		return r;
	endfunction

endpackage

/* hw/rtl/pbfe_ctrl.sv */
// controller state machine of the packet bit field extractor
// drives datapath commands and the handshakes; uses pbfe_pkg
`timescale 1ns / 1ps

module pbfe_ctrl
	import pbfe_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [CMD_BITS-1:0] cmd,
	output logic                out_valid,
	input  logic                out_ready,
	input  pbfe_stat_t          stat,
	output pbfe_ctl_t           ctl
);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_CHECK   = 3'd1;
	localparam logic [2:0] S_FILL    = 3'd2;
	localparam logic [2:0] S_LOAD    = 3'd3;
	localparam logic [2:0] S_EXTRACT = 3'd4;
	localparam logic [2:0] S_OUT     = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       accept;
	logic       out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					ctl.capture      = 1'b1;
					ctl.store_byte   = (cmd == CMD_STORE);
					ctl.clear_packet = (cmd == CMD_END);
					if (cmd == CMD_READ) begin
						state_d = S_CHECK;
					end else if (cmd == CMD_REALIGN) begin
						state_d = S_OUT;
					end
				end
			end
			S_CHECK: begin
				ctl.check = 1'b1;
				state_d   = stat.skip ? S_OUT : S_FILL;
			end
			S_FILL: begin
				if (stat.need_fill) begin
					ctl.fill_read = 1'b1;
					state_d       = S_LOAD;
				end else begin
					state_d = S_EXTRACT;
				end
			end
			S_LOAD: begin
				ctl.fill_load = 1'b1;
				state_d       = S_FILL;
			end
			S_EXTRACT: begin
				ctl.extract = 1'b1;
				state_d     = S_OUT;
			end
			S_OUT: begin
				// wait for the output register to be free
				if (out_free) begin
					ctl.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_rise_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result appeared outside the output state");

	a_no_result_cmds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (cmd == CMD_STORE || cmd == CMD_END) |=> state_q == S_IDLE)
		else $error("store or end item left the idle state");

	a_check_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd == CMD_READ |=> state_q == S_CHECK)
		else $error("read item did not enter the check state");

endmodule

/* hw/rtl/pbfe_dpath.sv */
// datapath of the packet bit field extractor: packet store, bit buffer,
// counters and result registers; uses pbfe_pkg
`timescale 1ns / 1ps

module pbfe_dpath
	import pbfe_pkg::*;
#(
	parameter int PACKET_BYTES = PBFE_PACKET_BYTES
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [CMD_BITS-1:0]    cmd,
	input  logic [7:0]             data_byte,
	input  logic [SIZE_BITS-1:0]   field_size,
	input  logic                   big_endian_order,
	input  logic                   swap_allowed,
	input  pbfe_ctl_t              ctl,
	output pbfe_stat_t             stat,
	output logic                   result_kind,
	output logic [FIELD_BITS-1:0]  field_value,
	output logic                   truncated,
	output logic [OFFSET_BITS-1:0] byte_offset
);

	localparam int CNT_W  = $clog2(PACKET_BYTES + 1);
	localparam int ADDR_W = $clog2(PACKET_BYTES);
	localparam int BITS_W = CNT_W + 4;

	logic [7:0]            mem [PACKET_BYTES];
	logic [7:0]            rd_data_q;

	logic [CNT_W-1:0]      stored_q;
	logic [CNT_W-1:0]      rdpos_q;
	logic [BUF_BITS-1:0]   buf_q;
	logic [SIZE_BITS-1:0]  cnt_q;

	logic [CMD_BITS-1:0]   cmd_q;
	logic [SIZE_BITS-1:0]  size_q;
	logic                  swap_q;

	logic [FIELD_BITS-1:0] res_value_q;
	logic                  res_trunc_q;

	logic [FIELD_BITS-1:0] kind_q_value;
	logic                  res_kind_q;
	logic                  res_tr_q;
	logic [OFFSET_BITS-1:0] res_off_q;

	logic [CNT_W-1:0]      remaining;
	logic [BITS_W-1:0]     avail_bits;
	logic                  short;
	logic [CNT_W-1:0]      new_rdpos;
	logic [FIELD_BITS-1:0] raw_value;
	logic [SIZE_BITS-1:0]  size_in;

	// oversize fields read as 64 bits
	assign size_in = (field_size > MAX_FIELD) ? MAX_FIELD : field_size;

	assign remaining  = stored_q - rdpos_q;
	assign avail_bits = BITS_W'({remaining, 3'b000}) + BITS_W'(cnt_q);
	assign short      = avail_bits < BITS_W'(size_q);
	assign new_rdpos  = rdpos_q - CNT_W'(cnt_q >> 3);
	assign raw_value  = buf_q[BUF_BITS-1 -: FIELD_BITS] >> (MAX_FIELD - size_q);

	assign stat.skip      = (size_q == '0) || short;
	assign stat.need_fill = (cnt_q < size_q) && (rdpos_q < stored_q);

	// packet store, registered read
	always_ff @(posedge clk) begin
		if (ctl.store_byte && stored_q < CNT_W'(PACKET_BYTES)) begin
			mem[stored_q[ADDR_W-1:0]] <= data_byte;
		end
		if (ctl.fill_read) begin
			rd_data_q <= mem[rdpos_q[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_q <= '0;
			rdpos_q  <= '0;
			buf_q    <= '0;
			cnt_q    <= '0;
		end else begin
			if (ctl.store_byte && stored_q < CNT_W'(PACKET_BYTES)) begin
				stored_q <= stored_q + CNT_W'(1);
			end
			if (ctl.clear_packet) begin
				stored_q <= '0;
				rdpos_q  <= '0;
				buf_q    <= '0;
				cnt_q    <= '0;
			end
			if (ctl.fill_read) begin
				rdpos_q <= rdpos_q + CNT_W'(1);
			end
			if (ctl.fill_load) begin
				// byte goes just below the bits already held
				buf_q <= buf_q | ({rd_data_q, 64'd0} >> cnt_q);
				cnt_q <= cnt_q + 7'd8;
			end
			if (ctl.extract) begin
				buf_q <= buf_q << size_q;
				cnt_q <= cnt_q - size_q;
			end
			if (ctl.load_out && cmd_q == CMD_REALIGN) begin
				rdpos_q <= new_rdpos;
				buf_q   <= '0;
				cnt_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q  <= cmd;
			size_q <= size_in;
			swap_q <= big_endian_order && swap_allowed;
		end
		if (ctl.check) begin
			res_value_q <= '0;
			res_trunc_q <= short;
		end
		if (ctl.extract) begin
			res_value_q <= swap_q ? host_swap(raw_value, size_q) : raw_value;
		end
		if (ctl.load_out) begin
			if (cmd_q == CMD_REALIGN) begin
				res_kind_q   <= 1'b1;
				kind_q_value <= '0;
				res_tr_q     <= 1'b0;
				res_off_q    <= OFFSET_BITS'(new_rdpos);
			end else begin
				res_kind_q   <= 1'b0;
				kind_q_value <= res_value_q;
				res_tr_q     <= res_trunc_q;
				res_off_q    <= '0;
			end
		end
	end

	assign result_kind = res_kind_q;
	assign field_value = kind_q_value;
	assign truncated   = res_tr_q;
	assign byte_offset = res_off_q;

	a_rd_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		rdpos_q <= stored_q)
		else $error("read position passed the stored byte count");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 7'd71)
		else $error("bit buffer count above buffer width");

	a_load_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fill_load |-> $past(ctl.fill_read))
		else $error("buffer loaded without a store read");

	a_fill_needed: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fill_read |-> cnt_q < size_q)
		else $error("refill issued with enough bits buffered");

endmodule

/* hw/rtl/packet_bit_field_extractor.sv */
// channel  | handshake            | payload
// input    | in_valid / in_ready  | cmd, data_byte, field_size, big_endian_order, swap_allowed
// output   | out_valid / out_ready| result_kind, field_value, truncated, byte_offset
//
// store and end-packet items return straight to idle; realign passes through the output
// state; a read passes through check, a store read and a buffer load for each byte refilled
// from the packet store, extract and output, or only check and output when truncated or empty
// reset is asynchronous and active low; the packet store has no reset
// a waiting result does not block the next item until a new result must be loaded
// top level: instantiates pbfe_ctrl and pbfe_dpath, uses pbfe_pkg
`timescale 1ns / 1ps

module packet_bit_field_extractor
	import pbfe_pkg::*;
#(
	parameter int PACKET_BYTES = PBFE_PACKET_BYTES
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [CMD_BITS-1:0]    cmd,
	input  logic [7:0]             data_byte,
	input  logic [SIZE_BITS-1:0]   field_size,
	input  logic                   big_endian_order,
	input  logic                   swap_allowed,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   result_kind,
	output logic [FIELD_BITS-1:0]  field_value,
	output logic                   truncated,
	output logic [OFFSET_BITS-1:0] byte_offset
);

	pbfe_ctl_t  ctl;
	pbfe_stat_t stat;

	pbfe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	pbfe_dpath #(
		.PACKET_BYTES (PACKET_BYTES)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.data_byte        (data_byte),
		.field_size       (field_size),
		.big_endian_order (big_endian_order),
		.swap_allowed     (swap_allowed),
		.ctl              (ctl),
		.stat             (stat),
		.result_kind      (result_kind),
		.field_value      (field_value),
		.truncated        (truncated),
		.byte_offset      (byte_offset)
	);

endmodule

/* bench/tb_top.sv */
// testbench for packet_bit_field_extractor: directed and random command items,
// a scoreboard class that predicts each result and compares it field by field
// depends on pbfe_pkg and the packet_bit_field_extractor rtl
`timescale 1ns / 1ps

module tb_top;
	import pbfe_pkg::*;

	localparam logic KIND_FIELD   = 1'b0;
	localparam logic KIND_REALIGN = 1'b1;
	localparam int   CYCLE_LIMIT  = 1000000;
	localparam int   ITEMS_PER_PHASE = 400;

	typedef struct packed {
		logic                   kind;
		logic [FIELD_BITS-1:0]  value;
		logic                   trunc;
		logic [OFFSET_BITS-1:0] offset;
	} extract_result_t;

	class extract_scoreboard;
		logic [7:0]      pkt_mem [PBFE_PACKET_BYTES];
		int unsigned     pkt_len;
		int unsigned     rd_pos;
		int unsigned     buf_cnt;
		logic [71:0]     bit_buf;
		extract_result_t pending_results [$];
		int              errors;

		function new();
			pkt_len = 0;
			rd_pos  = 0;
			buf_cnt = 0;
			bit_buf = '0;
			errors  = 0;
		endfunction

		// byte order of a big-endian field as a little-endian host would see it
		function logic [FIELD_BITS-1:0] host_order(logic [FIELD_BITS-1:0] v, int unsigned n);
			logic [FIELD_BITS-1:0] r;
			int unsigned           nbytes;
			nbytes = (n < 16) ? 0 : (n < 32) ? 2 : (n == 32) ? 4 : 8;
			if (nbytes == 0)
				return v;
			r = '0;
			for (int i = 0; i < nbytes; i++)
				r[8*i +: 8] = v[8*(nbytes-1-i) +: 8];
			return r;
		endfunction

		function void note_item(logic [CMD_BITS-1:0] c, logic [7:0] d,
				logic [SIZE_BITS-1:0] sz, logic be, logic sw);
			extract_result_t       r;
			int unsigned           n;
			logic [FIELD_BITS-1:0] v;
			r = '0;
			n = sz;
			if (n > 64)
				n = 64;
			case (c)
				CMD_STORE: begin
					if (pkt_len < PBFE_PACKET_BYTES) begin
						pkt_mem[pkt_len] = d;
						pkt_len++;
					end
					return;
				end
				CMD_END: begin
					pkt_len = 0;
					rd_pos  = 0;
					buf_cnt = 0;
					bit_buf = '0;
					return;
				end
				CMD_REALIGN: begin
					rd_pos  = rd_pos - buf_cnt / 8;
					buf_cnt = 0;
					bit_buf = '0;
					r.kind   = KIND_REALIGN;
					r.offset = rd_pos[OFFSET_BITS-1:0];
				end
				default: begin
					r.kind = KIND_FIELD;
					if (n != 0) begin
						if ((pkt_len - rd_pos) * 8 + buf_cnt < n) begin
							r.trunc = 1'b1;
						end else begin
							// refill below the bits already held, one byte at a time
							while (buf_cnt < n && rd_pos < pkt_len) begin
								bit_buf = bit_buf | ({64'd0, pkt_mem[rd_pos]} << (64 - buf_cnt));
								rd_pos++;
								buf_cnt += 8;
							end
							v = bit_buf[71:8] >> (64 - n);
							bit_buf = bit_buf << n;
							buf_cnt -= n;
							r.value = (be && sw) ? host_order(v, n) : v;
						end
					end
				end
			endcase
			pending_results.push_back(r);
		endfunction

		function void check_result(extract_result_t got);
			extract_result_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing expected, kind %0d value %h offset %0d",
					$time, got.kind, got.value, got.offset);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (got.kind !== want.kind) begin
				$display("%0t: result_kind expected %0d actual %0d", $time, want.kind, got.kind);
				errors++;
			end
			if (got.value !== want.value) begin
				$display("%0t: field_value expected %h actual %h", $time, want.value, got.value);
				errors++;
			end
			if (got.trunc !== want.trunc) begin
				$display("%0t: truncated expected %0d actual %0d", $time, want.trunc, got.trunc);
				errors++;
			end
			if (got.offset !== want.offset) begin
				$display("%0t: byte_offset expected %0d actual %0d",
					$time, want.offset, got.offset);
				errors++;
			end
		endfunction

		function int unsigned outstanding();
			return pending_results.size();
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic [CMD_BITS-1:0]    cmd;
	logic [7:0]             data_byte;
	logic [SIZE_BITS-1:0]   field_size;
	logic                   big_endian_order;
	logic                   swap_allowed;
	logic                   out_valid;
	logic                   out_ready;
	logic                   result_kind;
	logic [FIELD_BITS-1:0]  field_value;
	logic                   truncated;
	logic [OFFSET_BITS-1:0] byte_offset;

	extract_scoreboard sb;
	int unsigned       send_idle_pct;
	int unsigned       recv_stall_pct;
	int unsigned       items_sent;
	int unsigned       cycle_count;

	packet_bit_field_extractor dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.cmd              (cmd),
		.data_byte        (data_byte),
		.field_size       (field_size),
		.big_endian_order (big_endian_order),
		.swap_allowed     (swap_allowed),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.result_kind      (result_kind),
		.field_value      (field_value),
		.truncated        (truncated),
		.byte_offset      (byte_offset)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL packet_bit_field_extractor");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result('{result_kind, field_value, truncated, byte_offset});
	end

	task automatic send_item(input logic [CMD_BITS-1:0] c, input logic [7:0] d,
			input logic [SIZE_BITS-1:0] sz, input logic be, input logic sw);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid         <= 1'b1;
		cmd              <= c;
		data_byte        <= d;
		field_size       <= sz;
		big_endian_order <= be;
		swap_allowed     <= sw;
		do @(posedge clk); while (!in_ready);
		sb.note_item(c, d, sz, be, sw);
		items_sent++;
	endtask

	// hold off the sender until every expected result has come back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
	endtask

	function automatic logic [SIZE_BITS-1:0] pick_size();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 3)
			return '0;
		if (r < 6)
			return SIZE_BITS'($urandom_range(65, 127));
		if (r < 12)
			return MAX_FIELD;
		if (r < 25)
			return SIZE_BITS'($urandom_range(33, 64));
		return SIZE_BITS'($urandom_range(1, 32));
	endfunction

	// one packet: new packet, some bytes, then mostly reads with the odd realign,
	// late store or arbitrary item mixed in
	task automatic run_packet(input int unsigned len, input int unsigned ops);
		int unsigned r;
		send_item(CMD_END, 8'($urandom_range(255)), SIZE_BITS'($urandom_range(127)),
			1'($urandom_range(1)), 1'($urandom_range(1)));
		repeat (len)
			send_item(CMD_STORE, 8'($urandom_range(255)), SIZE_BITS'($urandom_range(127)),
				1'($urandom_range(1)), 1'($urandom_range(1)));
		repeat (ops) begin
			r = $urandom_range(99);
			if (r < 5)
				send_item(CMD_BITS'($urandom_range(3)), 8'($urandom_range(255)),
					SIZE_BITS'($urandom_range(127)), 1'($urandom_range(1)),
					1'($urandom_range(1)));
			else if (r < 12)
				send_item(CMD_REALIGN, 8'($urandom_range(255)), pick_size(),
					1'($urandom_range(1)), 1'($urandom_range(1)));
			else if (r < 20)
				send_item(CMD_STORE, 8'($urandom_range(255)), pick_size(),
					1'($urandom_range(1)), 1'($urandom_range(1)));
			else
				send_item(CMD_READ, 8'($urandom_range(255)), pick_size(),
					1'($urandom_range(1)), 1'($urandom_range(1)));
		end
	endtask

	task automatic run_until(input int unsigned target);
		while (items_sent < target)
			run_packet($urandom_range(0, 40), $urandom_range(1, 30));
	endtask

	initial begin
		logic [7:0] hdr [12];
		hdr = '{8'hff, 8'h00, 8'ha5, 8'h5a, 8'h01, 8'h23,
			8'h45, 8'h67, 8'h89, 8'hab, 8'hcd, 8'hef};
		sb               = new();
		cycle_count      = 0;
		items_sent       = 0;
		send_idle_pct    = 0;
		recv_stall_pct   = 0;
		arst_n           = 1'b0;
		in_valid         = 1'b0;
		cmd              = CMD_STORE;
		data_byte        = '0;
		field_size       = '0;
		big_endian_order = 1'b0;
		swap_allowed     = 1'b0;
		out_ready        = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty packet, zero size, extremes of size and swap rule
		send_item(CMD_END, 8'h00, 7'd0, 1'b0, 1'b0);
		send_item(CMD_READ, 8'h00, 7'd8, 1'b0, 1'b0);
		send_item(CMD_READ, 8'hff, 7'd0, 1'b1, 1'b1);
		send_item(CMD_REALIGN, 8'h00, 7'd0, 1'b0, 1'b0);
		foreach (hdr[i])
			send_item(CMD_STORE, hdr[i], 7'd0, 1'b0, 1'b0);
		send_item(CMD_READ, 8'h00, 7'd1, 1'b1, 1'b1);
		send_item(CMD_READ, 8'h00, MAX_FIELD, 1'b1, 1'b1);
		send_item(CMD_READ, 8'h00, 7'd24, 1'b1, 1'b1);
		send_item(CMD_READ, 8'h00, 7'd65, 1'b0, 1'b0);
		send_item(CMD_REALIGN, 8'h00, 7'd127, 1'b1, 1'b1);
		send_item(CMD_STORE, 8'h12, 7'd0, 1'b0, 1'b0);
		send_item(CMD_STORE, 8'h34, 7'd0, 1'b0, 1'b0);
		send_item(CMD_STORE, 8'h56, 7'd0, 1'b0, 1'b0);
		send_item(CMD_STORE, 8'h78, 7'd0, 1'b0, 1'b0);
		send_item(CMD_READ, 8'h00, 7'd32, 1'b1, 1'b1);
		send_item(CMD_END, 8'hff, 7'd127, 1'b1, 1'b1);
		drain();

		send_idle_pct  = 30;
		recv_stall_pct = 72;
		run_until(items_sent + ITEMS_PER_PHASE);
		drain();

		send_idle_pct  = 72;
		recv_stall_pct = 30;
		run_until(items_sent + ITEMS_PER_PHASE);
		drain();

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		run_until(items_sent + ITEMS_PER_PHASE);
		drain();

		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("PASS packet_bit_field_extractor");
		else
			$display("FAIL packet_bit_field_extractor");
		$finish;
	end

endmodule
